// ===== design/mmeu_pkg.sv =====
// ----------------------------------------------------------------------------
// mmeu_pkg
// Shared types and constants of the execute unit.
// ----------------------------------------------------------------------------
package mmeu_pkg;

  localparam logic [3:0] FUNC_NOP  = 4'd0;
  localparam logic [3:0] FUNC_ADD  = 4'd1;
  localparam logic [3:0] FUNC_SUB  = 4'd2;
  localparam logic [3:0] FUNC_MULT = 4'd3;
  localparam logic [3:0] FUNC_DIV  = 4'd4;
  localparam logic [3:0] FUNC_J    = 4'd5;
  localparam logic [3:0] FUNC_BNE  = 4'd6;
  localparam logic [3:0] FUNC_BEQ  = 4'd7;
  localparam logic [3:0] FUNC_LW   = 4'd8;
  localparam logic [3:0] FUNC_SW   = 4'd9;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DIV0    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [4:0] MULT_REG = 5'd24;
  localparam logic [4:0] DIV_REG  = 5'd25;

  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_DIV = 2'd1;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

// ===== design/mini_mips_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mini_mips_execute_unit
// One instruction per transaction; a new one is taken after the result of the
// previous one has been taken. Nop, j, branch, add, sub, sw and a divide by zero
// pass through read, execute and output states; lw adds a memory read state, and
// mult and div wait on the one-bit-per-cycle shared multiply/divide unit.
// After reset a clearing pass zeroes every entry of the data memory
// before the first transaction is taken; the register file resets through
// per-entry valid bits.
// ----------------------------------------------------------------------------
module mini_mips_execute_unit
  import mmeu_pkg::*;
#(
  parameter int REGISTER_COUNT = 32,
  parameter int DATA_DEPTH     = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_func,
  input  logic [4:0]         in_dest_reg,
  input  logic [4:0]         in_src_a_reg,
  input  logic [4:0]         in_src_b_reg,
  input  logic [7:0]         in_immediate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_next_pc,
  output logic               out_write_enable,
  output logic [4:0]         out_write_reg,
  output logic signed [31:0] out_write_value,
  output logic [1:0]         out_status
);

  localparam int RW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RDA   = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_ALU   = 3'd4;
  localparam logic [2:0] ST_MEM   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [7:0]  pc_r, pc_nxt;
  logic [3:0]  func_r;
  logic [4:0]  rd_r, ra_r, rb_r;
  logic [7:0]  imm_r;
  logic [31:0] a_r, b_r;
  logic [31:0] a_nxt, b_nxt;

  logic [31:0] regs [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rvalid_r;
  logic [31:0] mem [DATA_DEPTH];
  logic [31:0] mem_q_r;

  logic [7:0]  opc_r, opc_nxt;
  logic        owe_r, owe_nxt;
  logic [4:0]  oreg_r, oreg_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic [1:0]  ost_r, ost_nxt;

  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        rf_we;
  logic        rd_ok, imm_ok;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  function automatic logic [31:0] rf_read(
    input logic [4:0] idx,
    input logic [REGISTER_COUNT-1:0] vld,
    input logic [31:0] val
  );
    logic [31:0] r;
    r = 32'd0;
    if ({1'b0, idx} < 6'(REGISTER_COUNT) || REGISTER_COUNT > 32) begin
      if (vld[RW'(idx)]) r = val;
    end
    return r;
  endfunction

  mmeu_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign rd_ok  = (32'(rd_r) < 32'(REGISTER_COUNT));
  assign imm_ok = (32'(imm_r) < 32'(DATA_DEPTH));

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    pc_nxt    = pc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    opc_nxt   = opc_r;
    owe_nxt   = owe_r;
    oreg_nxt  = oreg_r;
    oval_nxt  = oval_r;
    ost_nxt   = ost_r;
    mem_we    = 1'b0;
    mem_wa    = AW'(imm_r);
    mem_wd    = rf_read(rd_r, rvalid_r, regs[RW'(rd_r)]);
    rf_we     = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = (func_r == FUNC_DIV) ? ALU_DIV : ALU_MUL;
    alu_req.a     = a_r;
    alu_req.b     = b_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r[AW-1:0];
        mem_wd = 32'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(DATA_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RDA;
      end
      ST_RDA: begin
        a_nxt = rf_read(ra_r, rvalid_r, regs[RW'(ra_r)]);
        b_nxt = rf_read(rb_r, rvalid_r, regs[RW'(rb_r)]);
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        opc_nxt  = pc_r + 8'd1;
        owe_nxt  = 1'b0;
        oreg_nxt = 5'd0;
        oval_nxt = 32'd0;
        ost_nxt  = STATUS_OK;
        state_nxt = ST_OUT;
        case (func_r)
          FUNC_NOP: ;
          FUNC_ADD, FUNC_SUB: begin
            owe_nxt  = rd_ok;
            oreg_nxt = rd_ok ? rd_r : 5'd0;
            oval_nxt = !rd_ok ? 32'd0 :
                       (func_r == FUNC_ADD) ? a_r + b_r : a_r - b_r;
          end
          FUNC_MULT: begin
            alu_req.start = 1'b1;
            state_nxt = ST_ALU;
          end
          FUNC_DIV: begin
            if (b_r == 32'd0) begin
              ost_nxt = STATUS_DIV0;
            end else begin
              alu_req.start = 1'b1;
              state_nxt = ST_ALU;
            end
          end
          FUNC_J: opc_nxt = imm_r;
          FUNC_BNE: if (a_r != b_r) opc_nxt = imm_r;
          FUNC_BEQ: if (a_r == b_r) opc_nxt = imm_r;
          FUNC_LW: state_nxt = ST_MEM;
          FUNC_SW: begin
            mem_we = imm_ok;
          end
          default: begin
            opc_nxt = pc_r;
            ost_nxt = STATUS_UNKNOWN;
          end
        endcase
      end
      ST_ALU: begin
        if (alu_rsp.done) begin
          owe_nxt  = 1'b1;
          oreg_nxt = (func_r == FUNC_DIV) ? DIV_REG : MULT_REG;
          oval_nxt = alu_rsp.result;
          state_nxt = ST_OUT;
        end
      end
      ST_MEM: begin
        owe_nxt  = rd_ok;
        oreg_nxt = rd_ok ? rd_r : 5'd0;
        oval_nxt = (rd_ok && imm_ok && imm_r != 8'd0) ? mem_q_r : 32'd0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          pc_nxt = opc_r;
          rf_we  = owe_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      pc_r     <= 8'd0;
      rvalid_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      if (rf_we) rvalid_r[RW'(oreg_r)] <= 1'b1;
    end
    if (state_r == ST_IDLE && in_valid) begin
      func_r <= in_func;
      rd_r   <= in_dest_reg;
      ra_r   <= in_src_a_reg;
      rb_r   <= in_src_b_reg;
      imm_r  <= in_immediate;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    opc_r  <= opc_nxt;
    owe_r  <= owe_nxt;
    oreg_r <= oreg_nxt;
    oval_r <= oval_nxt;
    ost_r  <= ost_nxt;
    if (rf_we) regs[RW'(oreg_r)] <= oval_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[AW'(imm_r)];
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_OUT);
  assign out_next_pc      = opc_r;
  assign out_write_enable = owe_r;
  assign out_write_reg    = oreg_r;
  assign out_write_value  = oval_r;
  assign out_status       = ost_r;

endmodule

// ===== design/mmeu_alu.sv =====
// ----------------------------------------------------------------------------
// mmeu_alu
// Shared multi-cycle unit: shift-add multiply and restoring divide, one bit
// per cycle.
// ----------------------------------------------------------------------------
module mmeu_alu
  import mmeu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] b_r, b_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  always_comb begin
    rem_sh  = {acc_r, q_r[31]};
    rem_sub = rem_sh - {1'b0, b_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      op_nxt   = req.op;
      acc_nxt  = 32'd0;
      if (req.op == ALU_DIV) begin
        q_nxt   = req.a[31] ? (32'd0 - req.a) : req.a;
        b_nxt   = req.b[31] ? (32'd0 - req.b) : req.b;
        neg_nxt = req.a[31] ^ req.b[31];
      end else begin
        q_nxt   = req.a;
        b_nxt   = req.b;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == ALU_DIV) begin
          q_nxt = neg_r ? (32'd0 - q_r) : q_r;
        end
      end else begin
        cnt_nxt = cnt_r + 6'd1;
        if (op_r == ALU_DIV) begin
          if (!rem_sub[32]) begin
            acc_nxt = rem_sub[31:0];
            q_nxt   = {q_r[30:0], 1'b1};
          end else begin
            acc_nxt = rem_sh[31:0];
            q_nxt   = {q_r[30:0], 1'b0};
          end
        end else begin
          if (q_r[0]) begin
            acc_nxt = acc_r + b_r;
          end
          q_nxt = q_r >> 1;
          b_nxt = b_r << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == ALU_DIV) ? q_r : acc_r;

endmodule

// ===== design/mmeu_checker.sv =====
// ----------------------------------------------------------------------------
// mmeu_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module mmeu_checker
  import mmeu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_write_enable,
  input logic [4:0]  out_write_reg,
  input logic [31:0] out_write_value,
  input logic [1:0]  out_status
);

  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken with result pending");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("result without execution");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_write_reg == 5'd0 && out_write_value == 32'd0))
    else $error("write fields not cleared");

  a_status_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> !out_write_enable)
    else $error("write reported with error status");

endmodule

bind mini_mips_execute_unit mmeu_checker u_mmeu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_write_enable (out_write_enable),
  .out_write_reg    (out_write_reg),
  .out_write_value  (out_write_value),
  .out_status       (out_status)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of mini_mips_execute_unit. Drives instructions with random gaps,
// predicts pc, register file and data memory in the bench, and checks every
// result transaction field by field against the predicted queue.
// ----------------------------------------------------------------------------
module tb_top;
  import mmeu_pkg::*;

  typedef struct {
    logic [7:0]  next_pc;
    logic        write_enable;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic [1:0]  status;
  } exec_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [3:0] in_func;
  logic [4:0] in_dest_reg;
  logic [4:0] in_src_a_reg;
  logic [4:0] in_src_b_reg;
  logic [7:0] in_immediate;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_next_pc;
  logic out_write_enable;
  logic [4:0] out_write_reg;
  logic signed [31:0] out_write_value;
  logic [1:0] out_status;

  logic [7:0]  pc_model;
  logic [31:0] regs_model [32];
  logic [31:0] mem_model [256];
  exec_result_t pending_results [$];
  int errors;
  int cycles;
  int hold_off;
  bit random_stall;

  mini_mips_execute_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic exec_result_t execute_instr(logic [3:0] f, logic [4:0] rd,
                                                 logic [4:0] ra, logic [4:0] rb,
                                                 logic [7:0] imm);
    exec_result_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] prod;
    logic [7:0] nxt;
    a = regs_model[ra];
    b = regs_model[rb];
    nxt = pc_model + 8'd1;
    r.write_enable = 1'b0;
    r.write_reg = '0;
    r.write_value = '0;
    r.status = STATUS_OK;
    case (f)
      FUNC_NOP: ;
      FUNC_ADD: begin
        r.write_enable = 1'b1; r.write_reg = rd; r.write_value = a + b;
      end
      FUNC_SUB: begin
        r.write_enable = 1'b1; r.write_reg = rd; r.write_value = a - b;
      end
      FUNC_MULT: begin
        prod = {32'd0, a} * {32'd0, b};
        r.write_enable = 1'b1; r.write_reg = MULT_REG; r.write_value = prod[31:0];
      end
      FUNC_DIV: begin
        if (b == 0) begin
          r.status = STATUS_DIV0;
        end else begin
          r.write_enable = 1'b1; r.write_reg = DIV_REG;
          r.write_value = signed_quotient(a, b);
        end
      end
      FUNC_J: nxt = imm;
      FUNC_BNE: if (a != b) nxt = imm;
      FUNC_BEQ: if (a == b) nxt = imm;
      FUNC_LW: begin
        r.write_enable = 1'b1; r.write_reg = rd;
        r.write_value = (imm != 0) ? mem_model[imm] : 32'd0;
      end
      FUNC_SW: mem_model[imm] = regs_model[rd];
      default: begin
        nxt = pc_model;
        r.status = STATUS_UNKNOWN;
      end
    endcase
    if (r.write_enable) regs_model[r.write_reg] = r.write_value;
    pc_model = nxt;
    r.next_pc = nxt;
    return r;
  endfunction

  task automatic send_instr(logic [3:0] f, logic [4:0] rd, logic [4:0] ra,
                            logic [4:0] rb, logic [7:0] imm);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_dest_reg <= rd;
    in_src_a_reg <= ra;
    in_src_b_reg <= rb;
    in_immediate <= imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_instr(f, rd, ra, rb, imm));
  endtask

  task automatic send_random(int n, int max_func);
    logic [31:0] v;
    repeat (n) begin
      v = $urandom;
      send_instr(4'($urandom_range(0, max_func)), v[4:0], v[9:5], v[14:10], v[22:15]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || !random_stall) begin
      out_stall <= hold_off > 0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0) || hold_off > 0;
    end
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(posedge clk) begin
    exec_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction pc=%0d", $time, out_next_pc);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.next_pc !== out_next_pc || e.write_enable !== out_write_enable ||
            e.write_reg !== out_write_reg || e.write_value !== out_write_value ||
            e.status !== out_status) begin
          $display("%0t: expected pc=%0d we=%0d reg=%0d val=%h st=%0d", $time,
                   e.next_pc, e.write_enable, e.write_reg, e.write_value, e.status);
          $display("%0t: actual   pc=%0d we=%0d reg=%0d val=%h st=%0d", $time,
                   out_next_pc, out_write_enable, out_write_reg, out_write_value,
                   out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("mini_mips_execute_unit: mismatch");
      $finish;
    end
  end

  task automatic test_extremes();
    // register values stay zero from reset; cover pc wrap, jumps, branches
    // and unknown functions
    send_instr(FUNC_SUB, 5'd1, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_LW, 5'd2, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_NOP, 5'd0, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_J, 5'd0, 5'd0, 5'd0, 8'd255);
    send_instr(FUNC_NOP, 5'd0, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_BEQ, 5'd0, 5'd0, 5'd0, 8'd200);
    send_instr(FUNC_BNE, 5'd0, 5'd0, 5'd0, 8'd7);
    send_instr(4'd15, 5'd0, 5'd0, 5'd0, 8'd0);
    send_instr(4'd10, 5'd31, 5'd31, 5'd31, 8'd255);
  endtask

  task automatic test_arith_corners();
    send_instr(FUNC_NOP, 5'd0, 5'd0, 5'd0, 8'd0);
    regs_setup();
    send_instr(FUNC_DIV, 5'd0, 5'd3, 5'd0, 8'd0);
    send_instr(FUNC_DIV, 5'd0, 5'd4, 5'd5, 8'd0);
    send_instr(FUNC_MULT, 5'd0, 5'd4, 5'd4, 8'd0);
    send_instr(FUNC_MULT, 5'd0, 5'd5, 5'd3, 8'd0);
    send_instr(FUNC_ADD, 5'd0, 5'd4, 5'd5, 8'd0);
    send_instr(FUNC_SW, 5'd4, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_SW, 5'd5, 5'd0, 5'd0, 8'd255);
    send_instr(FUNC_LW, 5'd31, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_LW, 5'd30, 5'd0, 5'd0, 8'd255);
    send_instr(FUNC_BNE, 5'd0, 5'd4, 5'd5, 8'd128);
  endtask

  task automatic regs_setup();
    // sub, a taken branch to zero, then a store and load at address one
    send_instr(FUNC_SUB, 5'd5, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_BEQ, 5'd0, 5'd0, 5'd0, 8'd0);
    send_instr(FUNC_SW, 5'd0, 5'd0, 5'd0, 8'd1);
    send_instr(FUNC_LW, 5'd3, 5'd0, 5'd0, 8'd1);
    regs_model[3] = regs_model[3];
  endtask

  task automatic test_random();
    // mostly legal instructions, some unknown functions
    repeat (1200) begin
      if ($urandom_range(0, 9) == 0) send_random(1, 15);
      else send_random(1, 9);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    send_random(30, 9);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_dest_reg = '0;
    in_src_a_reg = '0;
    in_src_b_reg = '0;
    in_immediate = '0;
    out_stall = 1'b0;
    errors = 0;
    cycles = 0;
    hold_off = 0;
    random_stall = 1'b0;
    pc_model = '0;
    foreach (regs_model[i]) regs_model[i] = '0;
    foreach (mem_model[i]) mem_model[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_arith_corners();
    random_stall = 1'b1;
    test_random();
    test_backpressure();
    wait_drain();
    if (errors == 0) begin
      $display("mini_mips_execute_unit: match");
    end else begin
      $display("mini_mips_execute_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mmeu_pkg.sv
design/mmeu_alu.sv
design/mini_mips_execute_unit.sv
design/mmeu_checker.sv
bench/tb_top.sv
